[sv/dmc_pkg.sv]
// ----------------------------------------------------------------------------
// dmc_pkg
// Shared types and constants for the depth-first maze carver.
// ----------------------------------------------------------------------------
package dmc_pkg;

  typedef struct packed {
    logic [1:0] kind;
    logic [4:0] cell_x;
    logic [4:0] cell_y;
  } dmc_in_t;

  typedef struct packed {
    logic [2:0] status;
    logic [4:0] new_x;
    logic [4:0] new_y;
    logic [1:0] cell_state;
    logic       cell_wall;
  } dmc_out_t;

  localparam logic [1:0] KIND_CARVE = 2'd0;
  localparam logic [1:0] KIND_READ  = 2'd1;
  localparam logic [1:0] KIND_CLEAR = 2'd2;

  localparam logic [1:0] CFG_START_X = 2'd0;
  localparam logic [1:0] CFG_START_Y = 2'd1;
  localparam logic [1:0] CFG_SEED    = 2'd2;

  localparam logic [2:0] STAT_CARVED   = 3'd0;
  localparam logic [2:0] STAT_FINISHED = 3'd1;
  localparam logic [2:0] STAT_ALREADY  = 3'd2;
  localparam logic [2:0] STAT_OK       = 3'd3;
  localparam logic [2:0] STAT_OVERFLOW = 3'd4;

  localparam logic [1:0] CELL_UNEXP = 2'd0;
  localparam logic [1:0] CELL_SIDE  = 2'd1;
  localparam logic [1:0] CELL_OPEN  = 2'd2;

  localparam logic [15:0] LFSR_TAPS = 16'hB400;

  // direction: 0 up, 1 right, 2 down, 3 left
  function automatic logic signed [2:0] dir_dx(input logic [1:0] d);
    logic signed [2:0] r;
    case (d)
      2'd1:    r = 3'sd1;
      2'd3:    r = -3'sd1;
      default: r = 3'sd0;
    endcase
    return r;
  endfunction

  function automatic logic signed [2:0] dir_dy(input logic [1:0] d);
    logic signed [2:0] r;
    case (d)
      2'd0:    r = -3'sd1;
      2'd2:    r = 3'sd1;
      default: r = 3'sd0;
    endcase
    return r;
  endfunction

  function automatic logic [15:0] lfsr_step(input logic [15:0] v);
    logic [15:0] r;
    r = v >> 1;
    if (v[0]) begin
      r = r ^ LFSR_TAPS;
    end
    return r;
  endfunction

endpackage

[sv/dfs_maze_carver_core.sv]
// ----------------------------------------------------------------------------
// dfs_maze_carver_core
// Randomized depth-first maze carver with grid memory and coordinate stack.
// ----------------------------------------------------------------------------
// Carve: push, neighbor scan on the grid read port, LFSR draws until a
//   carvable direction comes up, 4 writes; a backtrack pop rescans instead.
// Read: grid read through S_RDA and S_RDB. Clear: grid sweep, one cell/cycle.
// One item at a time; result register frees the output side.
// Reset is synchronous; after reset the grid sweep clears every cell
// with in_ready low.
module dfs_maze_carver_core #(
  parameter int GRID_W      = 32,
  parameter int GRID_H      = 32,
  parameter int STACK_DEPTH = 1024
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  dmc_pkg::dmc_in_t in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output dmc_pkg::dmc_out_t out_data,
  input  logic             cfg_we,
  input  logic [1:0]       cfg_index,
  input  logic [15:0]      cfg_wdata
);
  import dmc_pkg::*;

  localparam int XW    = $clog2(GRID_W);
  localparam int YW    = $clog2(GRID_H);
  localparam int XPW   = XW + 2;
  localparam int YPW   = YW + 2;
  localparam int CELLS = GRID_W * GRID_H;
  localparam int AW    = $clog2(CELLS);
  localparam int SAW   = $clog2(STACK_DEPTH);
  localparam int CNTW  = $clog2(STACK_DEPTH + 1);
  localparam int SW    = XW + YW;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_CLR   = 4'd1;
  localparam logic [3:0] S_PUSH  = 4'd2;
  localparam logic [3:0] S_SCAN  = 4'd3;
  localparam logic [3:0] S_POPRD = 4'd4;
  localparam logic [3:0] S_POPWB = 4'd5;
  localparam logic [3:0] S_DRAW  = 4'd6;
  localparam logic [3:0] S_WR    = 4'd7;
  localparam logic [3:0] S_RDA   = 4'd8;
  localparam logic [3:0] S_RDB   = 4'd9;
  localparam logic [3:0] S_DONE  = 4'd10;

  localparam logic [3:0] SC_LAST = 4'd8;
  localparam logic [3:0] SC_DEC  = 4'd9;

  // control
  logic [3:0]      state_r, state_nxt;
  logic [AW-1:0]   clr_addr_r, clr_addr_nxt;
  logic            clr_resp_r, clr_resp_nxt;
  logic [CNTW-1:0] cnt_r, cnt_nxt;
  logic [XW-1:0]   cur_x_r, cur_x_nxt;
  logic [YW-1:0]   cur_y_r, cur_y_nxt;
  logic            started_r, started_nxt;
  logic            finished_r, finished_nxt;
  logic [15:0]     lfsr_r, lfsr_nxt;
  logic [4:0]      start_x_r, start_x_nxt;
  logic [4:0]      start_y_r, start_y_nxt;
  logic [15:0]     seed_r, seed_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic [3:0]      sc_r, sc_nxt;
  logic [1:0]      wc_r, wc_nxt;

  // payload
  logic [2:0]    res_status_r, res_status_nxt;
  logic [1:0]    res_cs_r, res_cs_nxt;
  logic          res_cw_r, res_cw_nxt;
  logic [XW-1:0] rd_x_r, rd_x_nxt;
  logic [YW-1:0] rd_y_r, rd_y_nxt;
  logic          rd_ing_r, rd_ing_nxt;
  logic [2:0]    pk_r, pk_nxt;
  logic          ping_r, ping_nxt;
  logic [3:0]    adj_ok_r, adj_ok_nxt;
  logic [3:0]    two_ok_r, two_ok_nxt;
  logic [1:0]    dir_r, dir_nxt;
  dmc_out_t      out_data_r, out_data_nxt;

  // memories
  logic [1:0]  grid_mem [CELLS];
  logic [SW-1:0] stk_mem [STACK_DEPTH];
  logic          g_we;
  logic [AW-1:0] g_waddr, g_raddr;
  logic [1:0]    g_wdata, g_rdata_r;
  logic          s_we;
  logic [SAW-1:0] s_waddr, s_raddr;
  logic [SW-1:0] s_wdata, s_rdata_r;

  always_ff @(posedge clk) begin
    if (g_we) begin
      grid_mem[g_waddr] <= g_wdata;
    end
    g_rdata_r <= grid_mem[g_raddr];
  end

  always_ff @(posedge clk) begin
    if (s_we) begin
      stk_mem[s_waddr] <= s_wdata;
    end
    s_rdata_r <= stk_mem[s_raddr];
  end

  // shared probe unit: base + offset, in-grid test, cell address
  logic [XW-1:0]    base_x;
  logic [YW-1:0]    base_y;
  logic signed [2:0] off_x, off_y;
  logic [XPW-1:0]   probe_x;
  logic [YPW-1:0]   probe_y;
  logic             probe_ing;
  logic [AW-1:0]    probe_addr;

  always_comb begin
    base_x = (state_r == S_RDA) ? rd_x_r : cur_x_r;
    base_y = (state_r == S_RDA) ? rd_y_r : cur_y_r;
    off_x  = 3'sd0;
    off_y  = 3'sd0;
    case (state_r)
      S_SCAN: begin
        off_x = sc_r[0] ? (dir_dx(sc_r[2:1]) <<< 1) : dir_dx(sc_r[2:1]);
        off_y = sc_r[0] ? (dir_dy(sc_r[2:1]) <<< 1) : dir_dy(sc_r[2:1]);
      end
      S_WR: begin
        off_x = dir_dx(dir_r);
        off_y = dir_dy(dir_r);
        case (wc_r)
          2'd1: begin
            if (dir_r[0]) off_y = -3'sd1;
            else          off_x = -3'sd1;
          end
          2'd2: begin
            if (dir_r[0]) off_y = 3'sd1;
            else          off_x = 3'sd1;
          end
          2'd3: begin
            off_x = dir_dx(dir_r) <<< 1;
            off_y = dir_dy(dir_r) <<< 1;
          end
          default: begin
          end
        endcase
      end
      default: begin
      end
    endcase
    probe_x    = {2'b00, base_x} + {{(XPW-3){off_x[2]}}, off_x};
    probe_y    = {2'b00, base_y} + {{(YPW-3){off_y[2]}}, off_y};
    probe_ing  = !probe_x[XPW-1] && (probe_x < XPW'(GRID_W)) &&
                 !probe_y[YPW-1] && (probe_y < YPW'(GRID_H));
    probe_addr = AW'(AW'(probe_y[YW-1:0]) * AW'(GRID_W)) + AW'(probe_x[XW-1:0]);
  end

  logic         in_xfer;
  logic         scan_ok;
  logic [15:0]  lfsr_adv;
  logic [CNTW:0] cnt_plus2;

  assign in_ready  = (state_r == S_IDLE);
  assign in_xfer   = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign lfsr_adv  = lfsr_step(lfsr_r);
  assign cnt_plus2 = (CNTW+1)'(cnt_r) + (CNTW+1)'(2);
  assign scan_ok   = pk_r[0] ? (ping_r && (g_rdata_r == CELL_UNEXP))
                             : (!ping_r || (g_rdata_r == CELL_UNEXP));

  always_comb begin
    state_nxt      = state_r;
    clr_addr_nxt   = clr_addr_r;
    clr_resp_nxt   = clr_resp_r;
    cnt_nxt        = cnt_r;
    cur_x_nxt      = cur_x_r;
    cur_y_nxt      = cur_y_r;
    started_nxt    = started_r;
    finished_nxt   = finished_r;
    lfsr_nxt       = lfsr_r;
    start_x_nxt    = start_x_r;
    start_y_nxt    = start_y_r;
    seed_nxt       = seed_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    sc_nxt         = sc_r;
    wc_nxt         = wc_r;
    res_status_nxt = res_status_r;
    res_cs_nxt     = res_cs_r;
    res_cw_nxt     = res_cw_r;
    rd_x_nxt       = rd_x_r;
    rd_y_nxt       = rd_y_r;
    rd_ing_nxt     = rd_ing_r;
    pk_nxt         = pk_r;
    ping_nxt       = ping_r;
    adj_ok_nxt     = adj_ok_r;
    two_ok_nxt     = two_ok_r;
    dir_nxt        = dir_r;
    out_data_nxt   = out_data_r;
    g_we           = 1'b0;
    g_waddr        = probe_addr;
    g_wdata        = CELL_UNEXP;
    g_raddr        = probe_addr;
    s_we           = 1'b0;
    s_waddr        = cnt_r[SAW-1:0];
    s_wdata        = {cur_y_r, cur_x_r};
    s_raddr        = cnt_r[SAW-1:0];

    if (cfg_we) begin
      case (cfg_index)
        CFG_START_X: start_x_nxt = cfg_wdata[4:0];
        CFG_START_Y: start_y_nxt = cfg_wdata[4:0];
        CFG_SEED:    seed_nxt    = cfg_wdata;
        default: begin
        end
      endcase
    end

    case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          res_cs_nxt = CELL_UNEXP;
          res_cw_nxt = 1'b0;
          case (in_data.kind)
            KIND_CARVE: begin
              if (finished_r) begin
                res_status_nxt = STAT_ALREADY;
                state_nxt      = S_DONE;
              end else begin
                if (!started_r) begin
                  cur_x_nxt   = ({3'b000, start_x_r} < 8'(GRID_W)) ? XW'(start_x_r)
                                                                  : XW'(GRID_W - 1);
                  cur_y_nxt   = ({3'b000, start_y_r} < 8'(GRID_H)) ? YW'(start_y_r)
                                                                  : YW'(GRID_H - 1);
                  started_nxt = 1'b1;
                end
                state_nxt = S_PUSH;
              end
            end
            KIND_READ: begin
              rd_x_nxt   = XW'(in_data.cell_x);
              rd_y_nxt   = YW'(in_data.cell_y);
              rd_ing_nxt = ({3'b000, in_data.cell_x} < 8'(GRID_W)) &&
                           ({3'b000, in_data.cell_y} < 8'(GRID_H));
              state_nxt  = S_RDA;
            end
            KIND_CLEAR: begin
              cnt_nxt      = '0;
              cur_x_nxt    = '0;
              cur_y_nxt    = '0;
              started_nxt  = 1'b0;
              finished_nxt = 1'b0;
              lfsr_nxt     = (seed_r == 16'd0) ? 16'd1 : seed_r;
              clr_addr_nxt = '0;
              clr_resp_nxt = 1'b1;
              state_nxt    = S_CLR;
            end
            default: begin
              res_status_nxt = STAT_OK;
              state_nxt      = S_DONE;
            end
          endcase
        end
      end
      S_CLR: begin
        g_we    = 1'b1;
        g_waddr = clr_addr_r;
        g_wdata = CELL_UNEXP;
        if (clr_addr_r == AW'(CELLS - 1)) begin
          res_status_nxt = STAT_OK;
          state_nxt      = clr_resp_r ? S_DONE : S_IDLE;
        end else begin
          clr_addr_nxt = clr_addr_r + AW'(1);
        end
      end
      S_PUSH: begin
        if (cnt_plus2 > (CNTW+1)'(STACK_DEPTH)) begin
          res_status_nxt = STAT_OVERFLOW;
          state_nxt      = S_DONE;
        end else begin
          s_we      = 1'b1;
          cnt_nxt   = cnt_r + CNTW'(1);
          g_we      = 1'b1;
          g_wdata   = CELL_OPEN;
          sc_nxt    = '0;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (sc_r < SC_LAST) begin
          pk_nxt   = sc_r[2:0];
          ping_nxt = probe_ing;
        end
        if (sc_r != 4'd0 && sc_r <= SC_LAST) begin
          if (pk_r[0]) two_ok_nxt[pk_r[2:1]] = scan_ok;
          else         adj_ok_nxt[pk_r[2:1]] = scan_ok;
        end
        if (sc_r == SC_DEC) begin
          if (|(adj_ok_r & two_ok_r)) begin
            state_nxt = S_DRAW;
          end else if (cnt_r == '0) begin
            finished_nxt   = 1'b1;
            res_status_nxt = STAT_FINISHED;
            state_nxt      = S_DONE;
          end else begin
            cnt_nxt   = cnt_r - CNTW'(1);
            state_nxt = S_POPRD;
          end
        end else begin
          sc_nxt = sc_r + 4'd1;
        end
      end
      S_POPRD: begin
        state_nxt = S_POPWB;
      end
      S_POPWB: begin
        cur_x_nxt = s_rdata_r[XW-1:0];
        cur_y_nxt = s_rdata_r[SW-1:XW];
        sc_nxt    = '0;
        state_nxt = S_SCAN;
      end
      S_DRAW: begin
        lfsr_nxt = lfsr_adv;
        if (two_ok_r[lfsr_adv[1:0]]) begin
          dir_nxt   = lfsr_adv[1:0];
          wc_nxt    = '0;
          state_nxt = S_WR;
        end
      end
      S_WR: begin
        g_we    = probe_ing;
        g_wdata = (wc_r == 2'd1 || wc_r == 2'd2) ? CELL_SIDE : CELL_OPEN;
        wc_nxt  = wc_r + 2'd1;
        if (wc_r == 2'd0) begin
          s_we    = 1'b1;
          s_wdata = {probe_y[YW-1:0], probe_x[XW-1:0]};
          cnt_nxt = cnt_r + CNTW'(1);
        end
        if (wc_r == 2'd3) begin
          cur_x_nxt      = probe_x[XW-1:0];
          cur_y_nxt      = probe_y[YW-1:0];
          res_status_nxt = STAT_CARVED;
          state_nxt      = S_DONE;
        end
      end
      S_RDA: begin
        state_nxt = S_RDB;
      end
      S_RDB: begin
        res_cs_nxt     = rd_ing_r ? g_rdata_r : CELL_UNEXP;
        res_cw_nxt     = rd_ing_r ? (g_rdata_r != CELL_OPEN) : 1'b1;
        res_status_nxt = STAT_OK;
        state_nxt      = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt           = 1'b1;
          out_data_nxt.status     = res_status_r;
          out_data_nxt.new_x      = 5'(cur_x_r);
          out_data_nxt.new_y      = 5'(cur_y_r);
          out_data_nxt.cell_state = res_cs_r;
          out_data_nxt.cell_wall  = res_cw_r;
          state_nxt               = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_addr_r  <= '0;
      clr_resp_r  <= 1'b0;
      cnt_r       <= '0;
      cur_x_r     <= '0;
      cur_y_r     <= '0;
      started_r   <= 1'b0;
      finished_r  <= 1'b0;
      lfsr_r      <= 16'd1;
      start_x_r   <= '0;
      start_y_r   <= '0;
      seed_r      <= 16'd1;
      out_valid_r <= 1'b0;
      sc_r        <= '0;
      wc_r        <= '0;
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      clr_resp_r  <= clr_resp_nxt;
      cnt_r       <= cnt_nxt;
      cur_x_r     <= cur_x_nxt;
      cur_y_r     <= cur_y_nxt;
      started_r   <= started_nxt;
      finished_r  <= finished_nxt;
      lfsr_r      <= lfsr_nxt;
      start_x_r   <= start_x_nxt;
      start_y_r   <= start_y_nxt;
      seed_r      <= seed_nxt;
      out_valid_r <= out_valid_nxt;
      sc_r        <= sc_nxt;
      wc_r        <= wc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_status_r <= res_status_nxt;
    res_cs_r     <= res_cs_nxt;
    res_cw_r     <= res_cw_nxt;
    rd_x_r       <= rd_x_nxt;
    rd_y_r       <= rd_y_nxt;
    rd_ing_r     <= rd_ing_nxt;
    pk_r         <= pk_nxt;
    ping_r       <= ping_nxt;
    adj_ok_r     <= adj_ok_nxt;
    two_ok_r     <= two_ok_nxt;
    dir_r        <= dir_nxt;
    out_data_r   <= out_data_nxt;
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNTW'(STACK_DEPTH))
    else $error("stack count beyond depth");

  a_fin_started: assert property (@(posedge clk) disable iff (!rst_n)
    finished_r |-> started_r)
    else $error("finished without start");

  a_idle_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE || state_r == S_DONE) |-> (!g_we && !s_we))
    else $error("memory write outside a work state");

  a_dir_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DRAW && state_nxt == S_WR) |=> two_ok_r[dir_r])
    else $error("carving toward a blocked direction");

endmodule
